### hw/rtl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Types and fixed constants shared by the line pixel stepper modules.
// ----------------------------------------------------------------------------
package lps_pkg;

   // Screen dimension registers and the frame address have fixed widths.
   localparam int DIM_BITS  = 12;
   localparam int ADDR_BITS = 23;

   // Command codes carried on the request side.
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Register indexes of the configuration port.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      LINE_VERT    = 2'd0,
      LINE_HORZ    = 2'd1,
      LINE_SHALLOW = 2'd2,
      LINE_STEEP   = 2'd3
   } line_mode_type;

   typedef struct packed {
      logic active;
      logic last;
   } walk_flags_type;

   typedef struct packed {
      logic active;
      logic last;
      logic on_screen;
   } clip_flags_type;

endpackage

### hw/rtl/lps_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_walker
// Holds the line state, loads endpoints on a start word and steps one pixel
// per accepted word, registering the reported pixel.
// ----------------------------------------------------------------------------
module lps_walker #(
   parameter int COORD_BITS = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_command,
   input  logic signed [COORD_BITS-1:0] in_start_x,
   input  logic signed [COORD_BITS-1:0] in_start_y,
   input  logic signed [COORD_BITS-1:0] in_end_x,
   input  logic signed [COORD_BITS-1:0] in_end_y,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lps_pkg::walk_flags_type      out_flags,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y
);
   import lps_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DEC_BITS  = COORD_BITS + 3;
   localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   logic                         line_active_ff, line_active_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic signed [DEC_BITS-1:0]   straight_ff, straight_in, diagonal_ff, diagonal_in;
   line_mode_type                mode_ff, mode_in;
   logic                         ydir_ff, ydir_in;

   logic                         ov_ff, ov_in;
   walk_flags_type               oflags_ff, oflags_in;
   logic signed [COORD_BITS-1:0] ox_ff, ox_in, oy_ff, oy_in;

   logic                         fire, start;
   logic                         is_vert, is_horz, swap, steep;
   logic signed [COORD_BITS-1:0] ax, ay, bx, by;
   logic signed [DIFF_BITS-1:0]  dx, dy, ady;
   logic signed [DEC_BITS-1:0]   dxd, adyd;
   logic signed [DEC_BITS-1:0]   ld_dec, ld_str, ld_dia;
   line_mode_type                ld_mode;

   logic                         s_active, s_ydir, last;
   logic signed [COORD_BITS-1:0] s_x, s_y, s_sx, s_sy, y_step;
   logic signed [DEC_BITS-1:0]   s_dec, s_str, s_dia;
   line_mode_type                s_mode;

   assign in_ready  = !ov_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign start     = in_command == CMD_START;
   assign out_valid = ov_ff;
   assign out_flags = oflags_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;

   // Endpoint ordering and Bresenham set-up for a start word.
   always_comb begin
      is_vert = in_start_x == in_end_x;
      is_horz = in_start_y == in_end_y;
      swap    = is_vert ? (in_start_y > in_end_y) : (in_start_x > in_end_x);
      ax      = swap ? in_end_x : in_start_x;
      ay      = swap ? in_end_y : in_start_y;
      bx      = swap ? in_start_x : in_end_x;
      by      = swap ? in_start_y : in_end_y;
      dx      = DIFF_BITS'(bx) - DIFF_BITS'(ax);
      dy      = DIFF_BITS'(by) - DIFF_BITS'(ay);
      ady     = dy[DIFF_BITS-1] ? -dy : dy;
      steep   = ady > dx;
      dxd     = DEC_BITS'(dx);
      adyd    = DEC_BITS'(ady);
      if (is_vert) begin
         ld_mode = LINE_VERT;
      end else if (is_horz) begin
         ld_mode = LINE_HORZ;
      end else if (steep) begin
         ld_mode = LINE_STEEP;
      end else begin
         ld_mode = LINE_SHALLOW;
      end
      if (is_vert || is_horz) begin
         ld_dec = '0;
         ld_str = '0;
         ld_dia = '0;
      end else if (steep) begin
         ld_dec = dxd + dxd - adyd;
         ld_str = dxd + dxd;
         ld_dia = (dxd - adyd) + (dxd - adyd);
      end else begin
         ld_dec = adyd + adyd - dxd;
         ld_str = adyd + adyd;
         ld_dia = (adyd - dxd) + (adyd - dxd);
      end
   end

   // Report the current pixel, then step or finish the line.
   always_comb begin
      s_active = start ? 1'b1 : line_active_ff;
      s_x      = start ? ax : cur_x_ff;
      s_y      = start ? ay : cur_y_ff;
      s_sx     = start ? bx : stop_x_ff;
      s_sy     = start ? by : stop_y_ff;
      s_dec    = start ? ld_dec : decision_ff;
      s_str    = start ? ld_str : straight_ff;
      s_dia    = start ? ld_dia : diagonal_ff;
      s_mode   = start ? ld_mode : mode_ff;
      s_ydir   = start ? (!(is_vert || is_horz) && dy[DIFF_BITS-1]) : ydir_ff;

      if (s_mode == LINE_HORZ || s_mode == LINE_SHALLOW) begin
         last = s_x == s_sx;
      end else begin
         last = s_y == s_sy;
      end
      y_step = s_ydir ? s_y - ONE : s_y + ONE;

      cur_x_in    = s_x;
      cur_y_in    = s_y;
      decision_in = s_dec;
      case (s_mode)
         LINE_VERT: begin
            cur_y_in = s_y + ONE;
         end
         LINE_HORZ: begin
            cur_x_in = s_x + ONE;
         end
         LINE_SHALLOW: begin
            if (s_dec > 0) begin
               decision_in = s_dec + s_dia;
               cur_y_in    = y_step;
            end else begin
               decision_in = s_dec + s_str;
            end
            cur_x_in = s_x + ONE;
         end
         LINE_STEEP: begin
            if (s_dec >= 0) begin
               decision_in = s_dec + s_dia;
               cur_x_in    = s_x + ONE;
            end else begin
               decision_in = s_dec + s_str;
            end
            cur_y_in = y_step;
         end
         default: begin
            cur_x_in = s_x;
         end
      endcase

      line_active_in = line_active_ff;
      stop_x_in      = stop_x_ff;
      stop_y_in      = stop_y_ff;
      straight_in    = straight_ff;
      diagonal_in    = diagonal_ff;
      mode_in        = mode_ff;
      ydir_in        = ydir_ff;
      if (fire) begin
         line_active_in = s_active && !last;
         stop_x_in      = s_sx;
         stop_y_in      = s_sy;
         straight_in    = s_str;
         diagonal_in    = s_dia;
         mode_in        = s_mode;
         ydir_in        = s_ydir;
         if (!s_active || last) begin
            cur_x_in    = s_x;
            cur_y_in    = s_y;
            decision_in = s_dec;
         end
      end else begin
         cur_x_in    = cur_x_ff;
         cur_y_in    = cur_y_ff;
         decision_in = decision_ff;
      end

      ov_in     = ov_ff && !out_ready;
      oflags_in = oflags_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      if (fire) begin
         ov_in            = 1'b1;
         oflags_in.active = s_active;
         oflags_in.last   = s_active && last;
         ox_in            = s_active ? s_x : '0;
         oy_in            = s_active ? s_y : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         stop_x_ff      <= '0;
         stop_y_ff      <= '0;
         decision_ff    <= '0;
         straight_ff    <= '0;
         diagonal_ff    <= '0;
         mode_ff        <= LINE_VERT;
         ydir_ff        <= 1'b0;
         ov_ff          <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         stop_x_ff      <= stop_x_in;
         stop_y_ff      <= stop_y_in;
         decision_ff    <= decision_in;
         straight_ff    <= straight_in;
         diagonal_ff    <= diagonal_in;
         mode_ff        <= mode_in;
         ydir_ff        <= ydir_in;
         ov_ff          <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      oflags_ff <= oflags_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
   end

`ifndef NO_ASSERTIONS
   // A start word always reports a pixel of the new line.
   a_start_reports: assert property (@(posedge clock) disable iff (reset)
      fire && start |=> ov_ff && oflags_ff.active)
      else $error("start word did not report an active pixel");

   // Once the final pixel has gone out, the walker is idle.
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      fire && s_active && last |=> !line_active_ff)
      else $error("line still active after its final pixel");
`endif

endmodule

### hw/rtl/lps_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_clip
// Tests a reported pixel against the screen and works out its flipped row.
// ----------------------------------------------------------------------------
module lps_clip #(
   parameter int COORD_BITS = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lps_pkg::DIM_BITS-1:0]     screen_width,
   input  logic [lps_pkg::DIM_BITS-1:0]     screen_height,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  lps_pkg::walk_flags_type          in_flags,
   input  logic signed [COORD_BITS-1:0]     in_x,
   input  logic signed [COORD_BITS-1:0]     in_y,
   output logic                             out_valid,
   input  logic                             out_ready,
   output lps_pkg::clip_flags_type          out_flags,
   output logic [lps_pkg::DIM_BITS-1:0]     out_row,
   output logic signed [COORD_BITS-1:0]     out_x,
   output logic signed [COORD_BITS-1:0]     out_y
);
   import lps_pkg::*;

   localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 1;

   logic                         cv_ff, cv_in;
   clip_flags_type               cflags_ff, cflags_in;
   logic [DIM_BITS-1:0]          row_ff, row_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic signed [CMP_BITS-1:0]   xs, ys, ws, hs, diff;
   logic                         vis;

   assign in_ready  = !cv_ff || out_ready;
   assign out_valid = cv_ff;
   assign out_flags = cflags_ff;
   assign out_row   = row_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

   always_comb begin
      xs   = CMP_BITS'(in_x);
      ys   = CMP_BITS'(in_y);
      ws   = CMP_BITS'(screen_width);
      hs   = CMP_BITS'(screen_height);
      vis  = in_flags.active && xs >= 1 && xs <= ws && ys >= 1 && ys <= hs;
      diff = hs - ys;
      row_in              = vis ? diff[DIM_BITS-1:0] : '0;
      cflags_in.active    = in_flags.active;
      cflags_in.last      = in_flags.last;
      cflags_in.on_screen = vis;
      cv_in               = in_valid || (cv_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else begin
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         cflags_ff <= cflags_in;
         row_ff    <= row_in;
         x_ff      <= in_x;
         y_ff      <= in_y;
      end
   end

endmodule

### hw/rtl/lps_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_address
// Forms the frame word index row*width+x and holds the result word.
// ----------------------------------------------------------------------------
module lps_address #(
   parameter int COORD_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lps_pkg::DIM_BITS-1:0]      screen_width,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  lps_pkg::clip_flags_type           in_flags,
   input  logic [lps_pkg::DIM_BITS-1:0]      in_row,
   input  logic signed [COORD_BITS-1:0]      in_x,
   input  logic signed [COORD_BITS-1:0]      in_y,
   output logic                              out_valid,
   input  logic                              out_ready,
   output lps_pkg::clip_flags_type           out_flags,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic [lps_pkg::ADDR_BITS-1:0]     out_address
);
   import lps_pkg::*;

   localparam int PROD_BITS = 2 * DIM_BITS;

   logic                         av_ff, av_in;
   clip_flags_type               aflags_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic [ADDR_BITS-1:0]         addr_ff, addr_in;
   logic [PROD_BITS-1:0]         product, sum, x_wide;

   assign in_ready    = !av_ff || out_ready;
   assign out_valid   = av_ff;
   assign out_flags   = aflags_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_address = addr_ff;

   always_comb begin
      // An on-screen x is positive, so its sign extension is its value.
      x_wide  = PROD_BITS'(in_x);
      product = PROD_BITS'(in_row) * PROD_BITS'(screen_width);
      sum     = product + x_wide;
      addr_in = in_flags.on_screen ? sum[ADDR_BITS-1:0] : '0;
      av_in   = in_valid || (av_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else begin
         av_ff <= av_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         aflags_ff <= in_flags;
         x_ff      <= in_x;
         y_ff      <= in_y;
         addr_ff   <= addr_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_offscreen_zero: assert property (@(posedge clock) disable iff (reset)
      av_ff && !aflags_ff.on_screen |-> addr_ff == '0)
      else $error("off-screen pixel carries a non-zero address");

   a_onscreen_active: assert property (@(posedge clock) disable iff (reset)
      av_ff && aflags_ff.on_screen |-> aflags_ff.active)
      else $error("on-screen flag set on an idle word");
`endif

endmodule

### hw/rtl/line_pixel_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Line walker: one pixel word out for every command word in.
// ----------------------------------------------------------------------------
// The req stream carries a command in req_tuser: a start word loads two
// endpoints from req_tdata and reports the first pixel, an advance word
// reports the next pixel of the running line. Every request word yields
// exactly one rsp word: pixel x, y and frame address (height-y)*width+x in
// rsp_tdata, the active and on-screen flags in rsp_tuser, and rsp_tlast on
// the final pixel. An advance with no line running returns an all-zero word.
// A result word passes the walker output, clip and address registers before
// it is presented on rsp; one word is accepted every cycle while rsp_tready
// keeps the pipeline moving. The screen width and height registers sit at
// byte addresses 0 and 4 of the csr port; a write keeps its low 12 bits, and
// values above the maximum screen size saturate. Write them only while no
// words are in flight. Reset clears the line state and the pipeline and sets
// the screen to 640 by 480. If rsp_tready is held low the pipeline fills,
// and req_tready then drops until the result word is taken.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
   parameter int COORD_BITS = 13,
   parameter int SCREEN_MAX = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // start_x, start_y, end_x, end_y
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  logic [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x, pixel_y, pixel_address
   output logic [((2*COORD_BITS+lps_pkg::ADDR_BITS+7)/8)*8-1:0] rsp_tdata,
   // active, on_screen
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import lps_pkg::*;

   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + ADDR_BITS + 7) / 8) * 8;

   logic [DIM_BITS-1:0]          width_ff, width_in, height_ff, height_in;
   logic [DIM_BITS-1:0]          wvalue, wsat;
   logic                         csr_write;

   logic                         w_valid, w_ready;
   walk_flags_type               w_flags;
   logic signed [COORD_BITS-1:0] w_x, w_y;
   logic                         c_valid, c_ready;
   clip_flags_type               c_flags;
   logic [DIM_BITS-1:0]          c_row;
   logic signed [COORD_BITS-1:0] c_x, c_y;
   clip_flags_type               a_flags;
   logic signed [COORD_BITS-1:0] a_x, a_y;
   logic [ADDR_BITS-1:0]         a_address;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wvalue = csr_pwdata[DIM_BITS-1:0];
      wsat   = ((DIM_BITS + 1)'(wvalue) > (DIM_BITS + 1)'(SCREEN_MAX)) ?
               DIM_BITS'(SCREEN_MAX) : wvalue;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_in  = wsat;
            REG_HEIGHT: height_in = wsat;
            default:    width_in  = width_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = 32'(width_ff);
         REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   lps_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser[0]),
      .in_start_x (req_tdata[COORD_BITS-1:0]),
      .in_start_y (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_end_x   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .in_end_y   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .out_valid  (w_valid),
      .out_ready  (w_ready),
      .out_flags  (w_flags),
      .out_x      (w_x),
      .out_y      (w_y)
   );

   lps_clip #(.COORD_BITS(COORD_BITS)) u_clip (
      .clock         (clock),
      .reset         (reset),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .in_valid      (w_valid),
      .in_ready      (w_ready),
      .in_flags      (w_flags),
      .in_x          (w_x),
      .in_y          (w_y),
      .out_valid     (c_valid),
      .out_ready     (c_ready),
      .out_flags     (c_flags),
      .out_row       (c_row),
      .out_x         (c_x),
      .out_y         (c_y)
   );

   lps_address #(.COORD_BITS(COORD_BITS)) u_address (
      .clock        (clock),
      .reset        (reset),
      .screen_width (width_ff),
      .in_valid     (c_valid),
      .in_ready     (c_ready),
      .in_flags     (c_flags),
      .in_row       (c_row),
      .in_x         (c_x),
      .in_y         (c_y),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_flags    (a_flags),
      .out_x        (a_x),
      .out_y        (a_y),
      .out_address  (a_address)
   );

   assign rsp_tdata = RSP_DATA_BITS'({a_address, a_y, a_x});
   assign rsp_tuser = {a_flags.on_screen, a_flags.active};
   assign rsp_tlast = a_flags.last;

endmodule

### bench/line_pixel_stepper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_stepper_tb
// Self-checking bench for the line walker: start and advance words go in, and
// every pixel word that comes out is compared against a line tracker that
// walks the same lines in software. Screen size is changed between phases,
// including the saturating and zero cases, and both streams stall at random.
// ----------------------------------------------------------------------------
module line_pixel_stepper_tb;
   import lps_pkg::*;

   localparam int COORD_BITS = 13;
   localparam int SCREEN_MAX = 2048;

   typedef struct {
      bit        active;
      bit [12:0] x;
      bit [12:0] y;
      bit        on_screen;
      bit [22:0] address;
      bit        last;
   } pixel_word_type;

   // Walks lines exactly as the block should and queues the pixel words it expects.
   class line_tracker;
      int             width, height;
      bit             running;
      int             cx, cy, stop_x, stop_y;
      int             decision, step_straight, step_diag;
      line_mode_type  mode;
      bit             downward;
      pixel_word_type pending_pixels[$];
      int             errors;

      function new();
         width = 640;
         height = 480;
         running = 0;
         cx = 0; cy = 0; stop_x = 0; stop_y = 0;
         decision = 0; step_straight = 0; step_diag = 0;
         mode = LINE_VERT;
         downward = 0;
         errors = 0;
      endfunction

      function void set_dim(logic idx, logic [31:0] value);
         int v;
         v = value[11:0];
         if (v > SCREEN_MAX) v = SCREEN_MAX;
         if (idx == REG_WIDTH) width = v;
         else height = v;
      endfunction

      function void take_command(logic cmd, int ax, int ay, int bx, int by);
         pixel_word_type p;
         int             t, dx, ady, ys;
         bit             vis, fin;
         if (cmd == CMD_START) begin
            decision = 0; step_straight = 0; step_diag = 0;
            downward = 0;
            if (ax == bx) begin
               mode = LINE_VERT;
               if (ay > by) begin t = ay; ay = by; by = t; end
            end else if (ay == by) begin
               mode = LINE_HORZ;
               if (ax > bx) begin t = ax; ax = bx; bx = t; end
            end else begin
               if (ax > bx) begin
                  t = ax; ax = bx; bx = t;
                  t = ay; ay = by; by = t;
               end
               dx = bx - ax;
               ady = by - ay;
               downward = ady < 0;
               if (ady < 0) ady = -ady;
               if (ady > dx) begin
                  mode = LINE_STEEP;
                  decision = 2 * dx - ady;
                  step_straight = 2 * dx;
                  step_diag = 2 * (dx - ady);
               end else begin
                  mode = LINE_SHALLOW;
                  decision = 2 * ady - dx;
                  step_straight = 2 * ady;
                  step_diag = 2 * (ady - dx);
               end
            end
            cx = ax; cy = ay; stop_x = bx; stop_y = by;
            running = 1;
         end
         p = '{default: 0};
         if (running) begin
            if (mode == LINE_HORZ || mode == LINE_SHALLOW) fin = (cx == stop_x);
            else fin = (cy == stop_y);
            vis = cx >= 1 && cx <= width && cy >= 1 && cy <= height;
            p.active = 1;
            p.x = cx[12:0];
            p.y = cy[12:0];
            p.on_screen = vis;
            if (vis) p.address = 23'((height - cy) * width + cx);
            p.last = fin;
            if (fin) begin
               running = 0;
            end else begin
               ys = downward ? -1 : 1;
               case (mode)
                  LINE_VERT: cy += 1;
                  LINE_HORZ: cx += 1;
                  LINE_SHALLOW: begin
                     if (decision <= 0) begin
                        decision += step_straight;
                     end else begin
                        decision += step_diag;
                        cy += ys;
                     end
                     cx += 1;
                  end
                  default: begin
                     if (decision >= 0) begin
                        decision += step_diag;
                        cx += 1;
                     end else begin
                        decision += step_straight;
                     end
                     cy += ys;
                  end
               endcase
            end
         end
         pending_pixels.push_back(p);
      endfunction

      function void compare(string field, int expected, int actual);
         if (expected != actual) begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            errors++;
         end
      endfunction

      function void check_pixel(pixel_word_type got);
         pixel_word_type want;
         if (pending_pixels.size() == 0) begin
            $error("pixel word with nothing outstanding: x %0d y %0d",
                   $signed(got.x), $signed(got.y));
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         compare("active", want.active, got.active);
         compare("pixel_x", $signed(want.x), $signed(got.x));
         compare("pixel_y", $signed(want.y), $signed(got.y));
         compare("on_screen", want.on_screen, got.on_screen);
         compare("pixel_address", want.address, got.address);
         compare("last", want.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // start_x, start_y, end_x, end_y
   logic [55:0] req_tdata;
   // command
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   // pixel_x, pixel_y, pixel_address
   logic [55:0] rsp_tdata;
   // active, on_screen
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   line_tracker tracker;
   bit          quiet = 0;
   int          words_sent = 0;
   int          stall_left = 0;

   line_pixel_stepper #(
      .COORD_BITS(COORD_BITS),
      .SCREEN_MAX(SCREEN_MAX)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver back-pressure in bursts; a burst still running is dropped once
   // the quiet part of the run begins.
   always @(negedge clock) begin
      if (stall_left > 0 && !quiet) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.active = rsp_tuser[0];
         got.on_screen = rsp_tuser[1];
         got.x = rsp_tdata[12:0];
         got.y = rsp_tdata[25:13];
         got.address = rsp_tdata[48:26];
         got.last = rsp_tlast;
         tracker.check_pixel(got);
      end
   end

   // Entered at a falling edge; returns, req_tvalid still high, at the falling edge
   // after its word is taken; the caller then sends again or calls drain_pixels.
   task automatic send_word(input logic cmd, input int ax, input int ay,
                            input int bx, input int by);
      bit signed [12:0] sx, sy, ex, ey;
      sx = ax[12:0]; sy = ay[12:0]; ex = bx[12:0]; ey = by[12:0];
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      tracker.take_command(cmd, sx, sy, ex, ey);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_advance();
      send_word(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain_pixels();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (tracker.pending_pixels.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (tracker.pending_pixels.size() != 0) begin
         $error("%0d pixel words never arrived", tracker.pending_pixels.size());
         tracker.errors++;
         tracker.pending_pixels.delete();
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_dim(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Start word and advances; mostly the whole line, sometimes cut short or overrun.
   task automatic run_line(input int ax, input int ay, input int bx, input int by);
      int dx, dy, steps, adv;
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      steps = (dx > dy) ? dx : dy;
      if (steps <= 40 && $urandom_range(0, 99) < 85)
         adv = steps + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      else
         adv = $urandom_range(0, (steps < 30) ? steps : 30);
      send_word(CMD_START, ax, ay, bx, by);
      repeat (adv) send_advance();
   endtask

   task automatic random_phase(input int count);
      int target, pick, ax, ay, bx, by;
      target = words_sent + count;
      while (words_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_advance();
         end else if (pick < 75) begin
            // Short lines around the visible area, so the clip edges get crossed.
            ax = $urandom_range(0, tracker.width + 8) - 4;
            ay = $urandom_range(0, tracker.height + 8) - 4;
            bx = ax + $urandom_range(0, 48) - 24;
            by = ay + $urandom_range(0, 48) - 24;
            case ($urandom_range(0, 6))
               0: bx = ax;
               1: by = ay;
               default: ;
            endcase
            run_line(ax, ay, bx, by);
         end else begin
            ax = $signed(13'($urandom));
            ay = $signed(13'($urandom));
            bx = $signed(13'($urandom));
            by = $signed(13'($urandom));
            run_line(ax, ay, bx, by);
         end
      end
   endtask

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      tracker = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_ADVANCE;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Advance with no line running, then a single point and the idle after it.
      send_advance();
      send_word(CMD_START, 5, 5, 5, 5);
      send_advance();
      // Vertical given top first, on the top screen row.
      send_word(CMD_START, 1, 480, 1, 478);
      repeat (2) send_advance();
      // Horizontal given right to left, across the right screen edge.
      send_word(CMD_START, 641, 1, 638, 1);
      repeat (3) send_advance();
      // Shallow going down, starting off screen at x 0.
      send_word(CMD_START, 0, 3, 4, 1);
      repeat (4) send_advance();
      // Steep, given right to left.
      send_word(CMD_START, 10, 10, 9, 13);
      repeat (3) send_advance();
      // Exact diagonal, dropped after one step by the next start.
      send_word(CMD_START, 2, 2, 4, 4);
      send_advance();
      send_word(CMD_START, -4096, 4095, 4095, -4096);
      send_word(CMD_START, 4095, -4096, -4096, 4095);
      send_advance();
      random_phase(280);
      drain_pixels();

      // Values above the largest screen saturate.
      write_csr(REG_WIDTH, 32'hFFFF_FFFF);
      write_csr(REG_HEIGHT, SCREEN_MAX);
      random_phase(300);
      drain_pixels();

      write_csr(REG_WIDTH, 1);
      write_csr(REG_HEIGHT, 1);
      random_phase(250);
      drain_pixels();

      // A zero width leaves nothing on screen.
      write_csr(REG_WIDTH, 0);
      write_csr(REG_HEIGHT, 100);
      random_phase(250);
      drain_pixels();

      write_csr(REG_WIDTH, $urandom_range(1, SCREEN_MAX));
      write_csr(REG_HEIGHT, 32'h0000_1FFF);
      random_phase(300);
      drain_pixels();

      quiet = 1;
      write_csr(REG_WIDTH, 320);
      write_csr(REG_HEIGHT, 240);
      random_phase(550);
      drain_pixels();

      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
